>>> src/bgp_pkg.sv
`default_nettype none
package bgp_pkg;

  // Field and counter widths
  localparam int COUNT_BITS    = 16;
  localparam int POS_BITS      = 24;
  localparam int GW_BITS       = 7;
  localparam int GH_BITS       = 7;
  localparam int SPACING_BITS  = 8;
  localparam int COLS_BITS     = 9;
  localparam int CODE_BITS     = 8;
  localparam int ADV_BITS      = 12;
  localparam int IDX_BITS      = 7;
  localparam int TEX_PROD_BITS = 14;
  localparam int TEX_U_BITS    = 14;
  localparam int TEX_V_BITS    = 13;
  localparam int BOUND_BITS    = 27;
  localparam int W_PROD_BITS   = COUNT_BITS + ADV_BITS;
  localparam int H_PROD_BITS   = COUNT_BITS + GH_BITS;
  localparam int CALC_BITS     = ((W_PROD_BITS > BOUND_BITS) ? W_PROD_BITS : BOUND_BITS) + 1;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Divider sequencing: one quotient bit per cycle
  localparam int DIV_STEPS    = IDX_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

  // Character codes
  localparam logic [CODE_BITS-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_BITS-1:0] CODE_FIRST   = 8'd32;
  localparam logic [CODE_BITS-1:0] CODE_LAST    = 8'd127;

  // Register reset values
  localparam logic [GW_BITS-1:0]      GW_RESET      = 7'd8;
  localparam logic [GH_BITS-1:0]      GH_RESET      = 7'd8;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 8'd0;
  localparam logic [COLS_BITS-1:0]    COLS_RESET    = 9'd16;

  localparam logic [TEX_V_BITS-1:0] TEX_V_MAX = {TEX_V_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ORIGIN_X      = 3'd0,
    REG_ORIGIN_Y      = 3'd1,
    REG_GLYPH_WIDTH   = 3'd2,
    REG_GLYPH_HEIGHT  = 3'd3,
    REG_CHAR_SPACING  = 3'd4,
    REG_ATLAS_COLUMNS = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_DIV,
    ST_TEX,
    ST_BW,
    ST_BH,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] char_code;
    logic                 last_char;
  } in_t;

  typedef struct packed {
    logic                       glyph_valid;
    logic signed [POS_BITS-1:0] quad_x;
    logic signed [POS_BITS-1:0] quad_y;
    logic [TEX_U_BITS-1:0]      tex_u;
    logic [TEX_V_BITS-1:0]      tex_v;
    logic                       bounds_valid;
    logic [BOUND_BITS-1:0]      bound_width;
    logic [BOUND_BITS-1:0]      bound_height;
  } out_t;

  typedef struct packed {
    logic load;
    logic apply;
    logic div_step;
    logic mul_tex;
    logic mul_w;
    logic mul_h;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic printable;
    logic last;
    logic div_done;
    logic out_busy;
  } status_t;

  // Clamp a one-bit-wider sum to the signed position range
  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [POS_BITS:0] v);
    logic signed [POS_BITS-1:0] res;
    if (v[POS_BITS] != v[POS_BITS-1]) begin
      res = v[POS_BITS] ? {1'b1, {(POS_BITS-1){1'b0}}} : {1'b0, {(POS_BITS-1){1'b1}}};
    end else begin
      res = v[POS_BITS-1:0];
    end
    return res;
  endfunction

  // Increment a counter, holding at all ones
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS-1:0] res;
    res = (c == {COUNT_BITS{1'b1}}) ? c : c + 1'b1;
    return res;
  endfunction

  // Clamp a bound to its field width
  function automatic logic [BOUND_BITS-1:0] sat_bound(input logic [CALC_BITS-1:0] v);
    logic [BOUND_BITS-1:0] res;
    if (v > CALC_BITS'({BOUND_BITS{1'b1}})) begin
      res = {BOUND_BITS{1'b1}};
    end else begin
      res = v[BOUND_BITS-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> src/bitmap_text_glyph_placer_top.sv
// Channel  Direction  Handshake                  Payload
// in_      input      in_valid / in_ready        in_data (in_t: char_code, last_char)
// out_     output     out_valid / out_ready      out_data (out_t: glyph and bound fields)
// cfg_     input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A printable character goes through apply, a restoring divide for the atlas cell,
// the texture multiply and finish; a newline or other code goes through apply only. An item
// that ends the string also goes through the bound multiplies and then finish.
// Reset is synchronous, active low; cfg_ready is always high.
// A result waiting in the output register does not stop the next item from being
// taken; the item only holds in its last cycle until that register frees.
`default_nettype none
module bitmap_text_glyph_placer_top import bgp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_t                      in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_t                     out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  bgp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bgp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> src/bgp_ctrl.sv
`default_nettype none
module bgp_ctrl import bgp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequence one item: load, apply, then as needed divide, multiply and deliver
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        if (status.printable) begin
          state_nxt = ST_DIV;
        end else if (status.last) begin
          state_nxt = ST_BW;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_nxt = ST_TEX;
        end
      end
      ST_TEX: begin
        cmd.mul_tex = 1'b1;
        state_nxt   = status.last ? ST_BW : ST_FIN;
      end
      ST_BW: begin
        cmd.mul_w = 1'b1;
        state_nxt = ST_BH;
      end
      ST_BH: begin
        cmd.mul_h = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_load_to_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_APPLY))
    else $error("accepted item did not move to apply");

  a_div_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> status.printable)
    else $error("divider running for a non-printable item");

endmodule
`default_nettype wire

>>> src/bgp_dpath.sv
`default_nettype none
module bgp_dpath import bgp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output status_t                  status,
  input  in_t                      in_data,
  input  logic                     cfg_valid,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     out_ready,
  output logic                     out_valid,
  output out_t                     out_data
);

  // Configuration registers
  logic signed [POS_BITS-1:0] origin_x_r, origin_y_r;
  logic [GW_BITS-1:0]         gw_r;
  logic [GH_BITS-1:0]         gh_r;
  logic [SPACING_BITS-1:0]    spacing_r;
  logic [COLS_BITS-1:0]       cols_r;

  // Item registers
  logic [CODE_BITS-1:0] code_r;
  logic                 last_r;

  // Text state
  logic signed [POS_BITS-1:0] cursor_x_r, cursor_x_nxt;
  logic signed [POS_BITS-1:0] cursor_y_r, cursor_y_nxt;
  logic [COUNT_BITS-1:0]      line_chars_r, line_chars_nxt;
  logic [COUNT_BITS-1:0]      longest_r, longest_nxt;
  logic [COUNT_BITS-1:0]      line_count_r, line_count_nxt;

  // Working registers
  logic signed [POS_BITS-1:0] qx_r, qy_r;
  logic [IDX_BITS-1:0]        rem_r, quo_r;
  logic [DIV_CNT_BITS-1:0]    div_cnt_r;
  logic [TEX_PROD_BITS-1:0]   u_prod_r, v_prod_r;
  logic [W_PROD_BITS-1:0]     w_prod_r;
  logic [H_PROD_BITS-1:0]     h_prod_r;
  logic                       out_valid_r;
  out_t                       out_data_r;

  // Combinational terms
  logic                       printable;
  logic                       is_newline;
  logic [ADV_BITS-1:0]        advance;
  logic signed [POS_BITS:0]   x_sum, y_sum;
  logic [IDX_BITS-1:0]        div_idx;
  logic [COLS_BITS-1:0]       cols_eff;
  logic [IDX_BITS:0]          trial;
  logic [COLS_BITS:0]         trial_diff;
  logic                       trial_ge;
  logic [COUNT_BITS-1:0]      longest_cur;
  logic [CALC_BITS-1:0]       w_sub;
  out_t                       out_nxt;

  assign printable  = (code_r >= CODE_FIRST) && (code_r <= CODE_LAST);
  assign is_newline = (code_r == CODE_NEWLINE);
  assign advance    = ADV_BITS'({gw_r, 4'b0000}) + ADV_BITS'(spacing_r);
  assign x_sum      = {cursor_x_r[POS_BITS-1], cursor_x_r}
                    + {{(POS_BITS+1-ADV_BITS){1'b0}}, advance};
  assign y_sum      = {cursor_y_r[POS_BITS-1], cursor_y_r}
                    + {{(POS_BITS+1-GH_BITS-4){1'b0}}, gh_r, 4'b0000};
  assign div_idx    = IDX_BITS'(code_r - CODE_FIRST);
  assign cols_eff   = (cols_r == '0) ? COLS_BITS'(1) : cols_r;
  assign longest_cur = (line_chars_r > longest_r) ? line_chars_r : longest_r;

  // Restoring divide step: shift in the next dividend bit, subtract if it fits
  assign trial      = {rem_r, quo_r[IDX_BITS-1]};
  assign trial_diff = {{(COLS_BITS-IDX_BITS){1'b0}}, trial} - {1'b0, cols_eff};
  assign trial_ge   = !trial_diff[COLS_BITS];

  assign status.printable = printable;
  assign status.last      = last_r;
  assign status.div_done  = (div_cnt_r == DIV_LAST);
  assign status.out_busy  = out_valid_r && !out_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      gw_r       <= GW_RESET;
      gh_r       <= GH_RESET;
      spacing_r  <= SPACING_RESET;
      cols_r     <= COLS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ORIGIN_X:      origin_x_r <= $signed(cfg_data);
        REG_ORIGIN_Y:      origin_y_r <= $signed(cfg_data);
        REG_GLYPH_WIDTH:   gw_r       <= cfg_data[GW_BITS-1:0];
        REG_GLYPH_HEIGHT:  gh_r       <= cfg_data[GH_BITS-1:0];
        REG_CHAR_SPACING:  spacing_r  <= cfg_data[SPACING_BITS-1:0];
        REG_ATLAS_COLUMNS: cols_r     <= cfg_data[COLS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Next text state: character effect, string end, origin writes
  always_comb begin
    cursor_x_nxt   = cursor_x_r;
    cursor_y_nxt   = cursor_y_r;
    line_chars_nxt = line_chars_r;
    longest_nxt    = longest_r;
    line_count_nxt = line_count_r;
    if (cmd.apply) begin
      if (is_newline) begin
        cursor_x_nxt   = origin_x_r;
        cursor_y_nxt   = sat_pos(y_sum);
        longest_nxt    = longest_cur;
        line_chars_nxt = '0;
        line_count_nxt = bump(line_count_r);
      end else begin
        cursor_x_nxt = sat_pos(x_sum);
        if (printable) begin
          line_chars_nxt = bump(line_chars_r);
        end
      end
    end
    if (cmd.finish && last_r) begin
      cursor_x_nxt   = origin_x_r;
      cursor_y_nxt   = origin_y_r;
      line_chars_nxt = '0;
      longest_nxt    = '0;
      line_count_nxt = COUNT_BITS'(1);
    end
    if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X: cursor_x_nxt = $signed(cfg_data);
        REG_ORIGIN_Y: cursor_y_nxt = $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r   <= '0;
      cursor_y_r   <= '0;
      line_chars_r <= '0;
      longest_r    <= '0;
      line_count_r <= COUNT_BITS'(1);
    end else begin
      cursor_x_r   <= cursor_x_nxt;
      cursor_y_r   <= cursor_y_nxt;
      line_chars_r <= line_chars_nxt;
      longest_r    <= longest_nxt;
      line_count_r <= line_count_nxt;
    end
  end

  // Item capture, divider and products
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= in_data.char_code;
      last_r <= in_data.last_char;
    end
    if (cmd.apply) begin
      qx_r      <= cursor_x_r;
      qy_r      <= cursor_y_r;
      rem_r     <= '0;
      quo_r     <= div_idx;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= trial_ge ? trial_diff[IDX_BITS-1:0] : trial[IDX_BITS-1:0];
      quo_r     <= {quo_r[IDX_BITS-2:0], trial_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
    if (cmd.mul_tex) begin
      u_prod_r <= TEX_PROD_BITS'(rem_r) * TEX_PROD_BITS'(gw_r);
      v_prod_r <= TEX_PROD_BITS'(quo_r) * TEX_PROD_BITS'(gh_r);
    end
    if (cmd.mul_w) begin
      w_prod_r <= W_PROD_BITS'(longest_cur) * W_PROD_BITS'(advance);
    end
    if (cmd.mul_h) begin
      h_prod_r <= H_PROD_BITS'(line_count_r) * H_PROD_BITS'(gh_r);
    end
  end

  // Build the result; unused fields stay zero
  always_comb begin
    out_nxt = '0;
    w_sub   = CALC_BITS'(w_prod_r)
            - ((w_prod_r != '0) ? CALC_BITS'(spacing_r) : CALC_BITS'(0));
    out_nxt.glyph_valid  = printable;
    out_nxt.bounds_valid = last_r;
    if (printable) begin
      out_nxt.quad_x = qx_r;
      out_nxt.quad_y = qy_r;
      out_nxt.tex_u  = TEX_U_BITS'(u_prod_r);
      out_nxt.tex_v  = (v_prod_r > TEX_PROD_BITS'(TEX_V_MAX)) ? TEX_V_MAX
                     : v_prod_r[TEX_V_BITS-1:0];
    end
    if (last_r) begin
      out_nxt.bound_width  = sat_bound(w_sub);
      out_nxt.bound_height = sat_bound(CALC_BITS'({h_prod_r, 4'b0000}));
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_tex |-> ((16'(quo_r) * 16'(cols_eff) + 16'(rem_r)) == 16'(div_idx))
                    && (16'(rem_r) < 16'(cols_eff)))
    else $error("divider quotient or remainder wrong");

  a_out_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.glyph_valid || out_data_r.bounds_valid))
    else $error("result item with neither glyph nor bounds");

  a_unused_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.glyph_valid) |->
      ((out_data_r.quad_x == '0) && (out_data_r.quad_y == '0)
       && (out_data_r.tex_u == '0) && (out_data_r.tex_v == '0)))
    else $error("quad fields not cleared for a non-glyph result");

endmodule
`default_nettype wire
